// ===== design/sti_pkg.sv =====
// Package for the sorted table interpolation block: sizes, codes, types.
// No dependencies; every other file of the block but sti_ram imports it.
`default_nettype none
package sti_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int NUM_W       = ADDR_W + 1;
	localparam int CNT_W       = 11;
	localparam int TIME_W      = 48;
	localparam int VAL_W       = 32;
	localparam int IDX_W       = 10;
	localparam int FOUND_W     = 11;
	localparam int DIFF_W      = TIME_W + 1;
	localparam int DV_W        = VAL_W + 1;
	localparam int PROD_W      = DV_W + DIFF_W;
	localparam int QUO_W       = 41;
	localparam int SUM_W       = QUO_W + 1;
	localparam int DIV_CNT_W   = $clog2(PROD_W);
	localparam int MUL_LO_W    = 25;
	localparam int FIFO_DEPTH  = 2;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic                     kind;
		logic [IDX_W-1:0]         entry_index;
		logic signed [TIME_W-1:0] entry_time;
		logic signed [VAL_W-1:0]  entry_value;
		logic signed [TIME_W-1:0] query_time;
	} sti_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD_LO, ST_RD_HI, ST_CHECK, ST_MID, ST_EXV,
		ST_IP1, ST_IP2, ST_IP3, ST_MUL0, ST_MUL1, ST_DIV, ST_FIN, ST_DONE
	} sti_state_t;

endpackage
`default_nettype wire

// ===== design/sti_if.sv =====
// Handshake channel interfaces of the block: input word, result word, config.
// Depends on sti_pkg for field widths.
`default_nettype none
interface sti_in_if import sti_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic [IDX_W-1:0]         entry_index;
	logic signed [TIME_W-1:0] entry_time;
	logic signed [VAL_W-1:0]  entry_value;
	logic signed [TIME_W-1:0] query_time;
	modport source (output valid, kind, entry_index, entry_time, entry_value, query_time,
		input ready);
	modport sink (input valid, kind, entry_index, entry_time, entry_value, query_time,
		output ready);
endinterface

interface sti_out_if import sti_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [FOUND_W-1:0] found_index;
	logic                      exact_hit;
	logic signed [VAL_W-1:0]   result_value;
	modport source (output valid, found_index, exact_hit, result_value, input ready);
	modport sink (input valid, found_index, exact_hit, result_value, output ready);
endinterface

interface sti_cfg_if import sti_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== design/sti_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module sti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== design/sti_front.sv =====
// Front end: accepts input words into a two-entry queue for the back end.
// Depends on sti_pkg and sti_if.
`default_nettype none
module sti_front import sti_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sti_in_if.sink     in_ch,
	output logic       item_valid,
	output sti_item_t  item,
	input  wire logic  item_pop
);
	sti_item_t                   fifo_q [FIFO_DEPTH];
	logic [$clog2(FIFO_DEPTH)-1:0] wptr_q, rptr_q;
	logic [$clog2(FIFO_DEPTH):0]   count_q;
	logic                          push;

	assign in_ch.ready = (count_q != ($clog2(FIFO_DEPTH)+1)'(FIFO_DEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign item_valid  = (count_q != '0);
	assign item        = fifo_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= '{kind: in_ch.kind, entry_index: in_ch.entry_index,
				entry_time: in_ch.entry_time, entry_value: in_ch.entry_value,
				query_time: in_ch.query_time};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (item_pop) rptr_q <= rptr_q + 1'b1;
			case ({push, item_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== design/sti_back.sv =====
// Back end: table writes, binary search, interpolation with iterative divide,
// and the result register. Depends on sti_pkg, sti_if and sti_ram.
`default_nettype none
module sti_back import sti_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [CNT_W-1:0] entries,
	input  wire logic             item_valid,
	input  wire sti_item_t        item,
	output logic                  item_pop,
	sti_out_if.source             out_ch
);
	sti_state_t state_q, state_d;

	logic [ADDR_W-1:0]         t_raddr, v_raddr, waddr;
	logic                      we;
	logic [TIME_W-1:0]         t_rdata_u;
	logic [VAL_W-1:0]          v_rdata_u;
	logic signed [TIME_W-1:0]  t_rdata;
	logic signed [VAL_W-1:0]   v_rdata;
	logic [NUM_W-1:0]          n_cfg;

	logic signed [TIME_W-1:0]  q_q, tlo_q, thi_q, t2_q;
	logic [NUM_W-1:0]          n_q;
	logic [ADDR_W-1:0]         lo_q, hi_q;
	logic [NUM_W-1:0]          lo_inc, mid_sum;
	logic [ADDR_W-1:0]         mid;
	logic signed [FOUND_W-1:0] found_q;
	logic                      exact_q;
	logic signed [VAL_W-1:0]   res_q, v1_q;
	logic signed [DV_W-1:0]    dv_q;
	logic signed [DIFF_W-1:0]  dt_q, den_q;
	logic                      neg_q;
	logic [DV_W-1:0]           amag_q;
	logic [DIFF_W-1:0]         bmag_q, dmag_q;
	logic [PROD_W-1:0]         prod_q;
	logic [DIFF_W-1:0]         rem_q;
	logic [DIFF_W:0]           rem_x;
	logic [QUO_W-1:0]          quo_q, mag;
	logic                      sticky_q;
	logic [DIV_CNT_W-1:0]      cnt_q;
	logic signed [SUM_W-1:0]   sum;
	logic                      out_valid_q;
	logic signed [FOUND_W-1:0] out_found_q;
	logic                      out_exact_q;
	logic signed [VAL_W-1:0]   out_value_q;

	assign t_rdata = t_rdata_u;
	assign v_rdata = v_rdata_u;
	assign n_cfg   = (32'(entries) > TABLE_DEPTH) ? NUM_W'(TABLE_DEPTH) : NUM_W'(entries);
	assign lo_inc  = NUM_W'(lo_q) + 1'b1;
	assign mid_sum = NUM_W'(lo_q) + NUM_W'(hi_q);
	assign mid     = mid_sum[NUM_W-1:1];
	assign waddr   = ADDR_W'(item.entry_index);
	assign rem_x   = {rem_q, prod_q[PROD_W-1]};

	sti_ram #(.WIDTH(TIME_W), .DEPTH(TABLE_DEPTH)) u_times (
		.clk(clk), .we(we), .waddr(waddr), .wdata(item.entry_time),
		.raddr(t_raddr), .rdata(t_rdata_u));
	sti_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_values (
		.clk(clk), .we(we), .waddr(waddr), .wdata(item.entry_value),
		.raddr(v_raddr), .rdata(v_rdata_u));

	// Capped quotient magnitude and the signed sum before saturation.
	always_comb begin
		mag = (sticky_q || quo_q > (QUO_W'(1) << (QUO_W-1))) ?
			(QUO_W'(1) << (QUO_W-1)) : quo_q;
		sum = neg_q ? SUM_W'(v1_q) - $signed({1'b0, mag}) :
			SUM_W'(v1_q) + $signed({1'b0, mag});
	end

	always_comb begin
		state_d  = state_q;
		item_pop = 1'b0;
		we       = 1'b0;
		t_raddr  = '0;
		v_raddr  = '0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					item_pop = 1'b1;
					if (item.kind == KIND_WRITE) begin
						we = (32'(item.entry_index) < TABLE_DEPTH);
					end else if (n_cfg == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_RD_LO;
					end
				end
			end
			ST_RD_LO: begin
				t_raddr = ADDR_W'(n_q - 1'b1);
				state_d = ST_RD_HI;
			end
			ST_RD_HI: begin
				if (q_q < tlo_q || q_q > t_rdata) state_d = ST_DONE;
				else state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (tlo_q == q_q) begin
					v_raddr = lo_q;
					state_d = ST_EXV;
				end else if (thi_q == q_q) begin
					v_raddr = hi_q;
					state_d = ST_EXV;
				end else if (lo_q == hi_q) begin
					state_d = ST_DONE;
				end else if (lo_inc == NUM_W'(hi_q)) begin
					t_raddr = ADDR_W'(lo_inc);
					v_raddr = lo_q;
					state_d = ST_IP1;
				end else begin
					t_raddr = mid;
					state_d = ST_MID;
				end
			end
			ST_MID:  state_d = ST_CHECK;
			ST_EXV:  state_d = ST_DONE;
			ST_IP1: begin
				v_raddr = ADDR_W'(lo_inc);
				state_d = ST_IP2;
			end
			ST_IP2:  state_d = ST_IP3;
			ST_IP3: begin
				if (den_q == '0 || dv_q == '0 || dt_q == '0) state_d = ST_DONE;
				else state_d = ST_MUL0;
			end
			ST_MUL0: state_d = ST_MUL1;
			ST_MUL1: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == DIV_CNT_W'(PROD_W-1)) state_d = ST_FIN;
			end
			ST_FIN:  state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && !out_valid_q) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				q_q     <= item.query_time;
				n_q     <= n_cfg;
				lo_q    <= '0;
				hi_q    <= ADDR_W'(n_cfg - 1'b1);
				found_q <= '1;
				exact_q <= 1'b0;
				res_q   <= '0;
			end
			ST_RD_LO: tlo_q <= t_rdata;
			ST_RD_HI: begin
				thi_q <= t_rdata;
				if (q_q >= tlo_q && q_q > t_rdata) found_q <= FOUND_W'(n_q - 1'b1);
			end
			ST_CHECK: begin
				if (tlo_q == q_q) begin
					found_q <= FOUND_W'(lo_q);
					exact_q <= 1'b1;
				end else if (thi_q == q_q) begin
					found_q <= FOUND_W'(hi_q);
					exact_q <= 1'b1;
				end else if (lo_q == hi_q || lo_inc == NUM_W'(hi_q)) begin
					found_q <= FOUND_W'(lo_q);
				end
			end
			ST_MID: begin
				if (q_q < t_rdata) begin
					hi_q  <= mid;
					thi_q <= t_rdata;
				end else begin
					lo_q  <= mid;
					tlo_q <= t_rdata;
				end
			end
			ST_EXV: res_q <= v_rdata;
			ST_IP1: begin
				t2_q <= t_rdata;
				v1_q <= v_rdata;
			end
			ST_IP2: begin
				dv_q  <= DV_W'(v_rdata) - DV_W'(v1_q);
				dt_q  <= DIFF_W'(q_q) - DIFF_W'(tlo_q);
				den_q <= DIFF_W'(t2_q) - DIFF_W'(tlo_q);
			end
			ST_IP3: begin
				res_q    <= v1_q;
				neg_q    <= (dv_q[DV_W-1] ^ dt_q[DIFF_W-1]) ^ den_q[DIFF_W-1];
				amag_q   <= dv_q[DV_W-1] ? DV_W'(-dv_q) : DV_W'(dv_q);
				bmag_q   <= dt_q[DIFF_W-1] ? DIFF_W'(-dt_q) : DIFF_W'(dt_q);
				dmag_q   <= den_q[DIFF_W-1] ? DIFF_W'(-den_q) : DIFF_W'(den_q);
				rem_q    <= '0;
				quo_q    <= '0;
				sticky_q <= 1'b0;
				cnt_q    <= '0;
			end
			ST_MUL0: prod_q <= PROD_W'(amag_q * bmag_q[MUL_LO_W-1:0]);
			ST_MUL1: prod_q <= prod_q +
				(PROD_W'(amag_q * bmag_q[DIFF_W-1:MUL_LO_W]) << MUL_LO_W);
			ST_DIV: begin
				// One restoring divide step per cycle, most significant bit first.
				prod_q   <= prod_q << 1;
				cnt_q    <= cnt_q + 1'b1;
				sticky_q <= sticky_q | quo_q[QUO_W-1];
				if (rem_x >= {1'b0, dmag_q}) begin
					rem_q <= DIFF_W'(rem_x - {1'b0, dmag_q});
					quo_q <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_x[DIFF_W-1:0];
					quo_q <= {quo_q[QUO_W-2:0], 1'b0};
				end
			end
			ST_FIN: begin
				if (sum > SUM_W'(32'sh7FFF_FFFF)) res_q <= 32'sh7FFF_FFFF;
				else if (sum < SUM_W'(32'sh8000_0000)) res_q <= 32'sh8000_0000;
				else res_q <= VAL_W'(sum);
			end
			ST_DONE: begin
				if (!out_valid_q) begin
					out_found_q <= found_q;
					out_exact_q <= exact_q;
					out_value_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.found_index  = out_found_q;
	assign out_ch.exact_hit    = out_exact_q;
	assign out_ch.result_value = out_value_q;

	a_search_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> (lo_q <= hi_q))
		else $error("search bounds crossed");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |=> $stable(out_found_q) && $stable(out_value_q))
		else $error("waiting result overwritten");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q <= DIV_CNT_W'(PROD_W-1)))
		else $error("divider ran past its length");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |-> (state_q == ST_IDLE && item_valid))
		else $error("queue popped outside idle");
endmodule
`default_nettype wire

// ===== design/sorted_table_interpolation_top.sv =====
// Top level of the sorted table interpolation block.
// Depends on sti_pkg, sti_if, sti_front, sti_back (and sti_ram below it).
//
//   Channel  Dir  Payload                                           Accepted when
//   in_ch    in   kind, entry_index, entry_time, entry_value,       valid && ready
//                 query_time
//   out_ch   out  found_index, exact_hit, result_value              valid && ready
//   cfg_ch   in   data (entries_in_use)                             valid && ready
//
// A table write is done by the back end in its idle state. A query first reads
// both ends of the table, then each binary search step passes ST_CHECK and
// ST_MID (one memory read of the time table per step); an interpolation forms
// two partial products and then runs the bit-serial divider, which dominates.
// Reset clears the queue, the sequencer and the register count; the table
// memories are not cleared and hold nothing meaningful until written.
// The two-entry input queue keeps taking words while a result waits on out_ch, until full.
`default_nettype none
module sorted_table_interpolation_top import sti_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	sti_in_if.sink    in_ch,
	sti_out_if.source out_ch,
	sti_cfg_if.sink   cfg_ch
);
	logic [CNT_W-1:0] entries_q;
	logic             item_valid;
	logic             item_pop;
	sti_item_t        item;

	// The count register is always writable; software must write it only when idle.
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= '0;
		end else if (cfg_ch.valid) begin
			entries_q <= cfg_ch.data;
		end
	end

	sti_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.item_valid(item_valid), .item(item), .item_pop(item_pop));

	sti_back u_back (
		.clk(clk), .arst_n(arst_n), .entries(entries_q),
		.item_valid(item_valid), .item(item), .item_pop(item_pop), .out_ch(out_ch));
endmodule
`default_nettype wire

// ===== tb/sv/tb_sorted_table_interpolation_top.sv =====
// Testbench for sorted_table_interpolation_top: fills the sample table, sets the entry
// count and checks every query result against a typed answer or a local predictor.
// Depends on sti_pkg, the sti_if channel interfaces and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_sorted_table_interpolation_top;
	import sti_pkg::*;

	localparam int  CYCLE_LIMIT = 1500000;
	localparam int  DRAIN_WAIT  = 150;
	localparam longint TIME_MIN = -(64'sd1 <<< 47);
	localparam longint TIME_MAX = (64'sd1 <<< 47) - 1;
	localparam longint VAL_MIN  = -(64'sd1 <<< 31);
	localparam longint VAL_MAX  = (64'sd1 <<< 31) - 1;

	// One result word as the block returns it.
	typedef struct {
		logic signed [FOUND_W-1:0] found;
		logic                      exact;
		logic signed [VAL_W-1:0]   value;
	} lookup_t;

	typedef enum int {ROW_WRITE, ROW_QUERY, ROW_COUNT} row_op_t;

	// One row of the directed table. Rows with a typed answer bypass the predictor.
	typedef struct {
		row_op_t op;
		int      idx;
		longint  t;
		longint  v;
		bit      typed;
		lookup_t ans;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sti_in_if  in_ch();
	sti_out_if out_ch();
	sti_cfg_if cfg_ch();

	sorted_table_interpolation_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source),
		.cfg_ch (cfg_ch.sink)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the table and of the entry count.
	longint  shadow_time [TABLE_DEPTH];
	longint  shadow_value [TABLE_DEPTH];
	int      shadow_count = 0;

	lookup_t pending_lookups [$];
	dir_row_t dir_rows [$];
	int      errors = 0;
	int      results_seen = 0;
	int      in_idle_pct = 18;
	int      out_idle_pct = 68;
	int      hold_left = 0;
	bit      hold_done = 1'b0;
	int      cycles = 0;

	// The run is bounded by a plain cycle count.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_sorted_table_interpolation_top: errors");
			$finish;
		end
	end

	function automatic longint rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic longint sx48(logic [63:0] x);
		return {{16{x[47]}}, x[47:0]};
	endfunction

	function automatic longint sx32(logic [63:0] x);
		return {{32{x[31]}}, x[31:0]};
	endfunction

	function automatic logic [63:0] magnitude(longint x);
		return (x < 0) ? -x : x;
	endfunction

	// Binary search plus interpolation, following the block's lookup rules.
	function automatic lookup_t lookup_value(longint q);
		lookup_t      r;
		int           n, lo, hi, mid, f;
		bit           hit;
		longint       t1, t2, v1, v2, dv, dt, den, res;
		logic [127:0] prod, quo;
		bit           neg;
		n = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_count;
		f = -1;
		hit = 1'b0;
		res = 0;
		if (n == 0 || q < shadow_time[0]) begin
			f = -1;
		end else if (q > shadow_time[n-1]) begin
			f = n - 1;
		end else begin
			lo = 0;
			hi = n - 1;
			forever begin
				if (shadow_time[lo] == q) begin
					f = lo; hit = 1'b1; break;
				end
				if (shadow_time[hi] == q) begin
					f = hi; hit = 1'b1; break;
				end
				if (lo == hi || lo + 1 == hi) begin
					f = lo; break;
				end
				mid = (lo + hi) / 2;
				if (q < shadow_time[mid]) hi = mid;
				else lo = mid;
			end
		end
		if (hit) begin
			res = shadow_value[f];
		end else if (f >= 0 && f + 1 < n) begin
			t1 = shadow_time[f];
			t2 = shadow_time[f+1];
			v1 = shadow_value[f];
			v2 = shadow_value[f+1];
			dv = v2 - v1;
			dt = q - t1;
			den = t2 - t1;
			res = v1;
			if (den != 0 && dv != 0 && dt != 0) begin
				neg = ((dv < 0) != (dt < 0)) != (den < 0);
				prod = {64'd0, magnitude(dv)} * {64'd0, magnitude(dt)};
				quo = prod / {64'd0, magnitude(den)};
				// The quotient is capped at 2^40, far beyond any 32-bit value.
				if (quo > (128'd1 << 40)) quo = 128'd1 << 40;
				res = neg ? v1 - longint'(quo[63:0]) : v1 + longint'(quo[63:0]);
			end
			if (res > VAL_MAX) res = VAL_MAX;
			if (res < VAL_MIN) res = VAL_MIN;
		end
		r.found = FOUND_W'(f);
		r.exact = hit;
		r.value = VAL_W'(res);
		return r;
	endfunction

	// Offers one word on in_ch, with a random gap first, and books what the
	// block should answer once the word is taken. The valid line is only
	// lowered when a gap is taken, so back-to-back words keep it high.
	task automatic send_word(input logic kind, input int idx, input longint t, input longint v,
			input bit typed, input lookup_t ans);
		if ($urandom_range(99) < in_idle_pct) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= kind;
		in_ch.entry_index <= IDX_W'(idx);
		in_ch.entry_time <= TIME_W'((kind == KIND_WRITE) ? t : rand64());
		in_ch.entry_value <= VAL_W'(v);
		in_ch.query_time <= TIME_W'((kind == KIND_QUERY) ? t : rand64());
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		if (kind == KIND_WRITE) begin
			shadow_time[idx] = sx48(t);
			shadow_value[idx] = sx32(v);
		end else begin
			pending_lookups.push_back(typed ? ans : lookup_value(sx48(t)));
		end
	endtask

	task automatic write_sample(input int idx, input longint t, input longint v);
		lookup_t none;
		send_word(KIND_WRITE, idx, t, v, 1'b0, none);
	endtask

	task automatic query_time(input longint q);
		lookup_t none;
		send_word(KIND_QUERY, 0, q, rand64(), 1'b0, none);
	endtask

	// The count register is only written with the block idle: every result
	// in, and a drain wait so that trailing table writes have landed.
	task automatic set_entry_count(input int n);
		in_ch.valid <= 1'b0;
		while (pending_lookups.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= CNT_W'(n);
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		shadow_count = n;
	endtask

	// Writes entries 0..n-1. Style 0 spreads times over the full range, style 1
	// packs them tightly with repeats, style 2 leaves them in random order.
	task automatic load_table(input int n, input int style);
		longint times [$];
		longint t;
		int     i;
		times = {};
		t = sx48(rand64()) / 2;
		for (i = 0; i < n; i++) begin
			if (style == 1) begin
				t = t + (($urandom_range(7) == 0) ? longint'($urandom_range(1 << 20))
					: longint'($urandom_range(3)));
				if (t > TIME_MAX) t = TIME_MAX;
				times.push_back(t);
			end else begin
				times.push_back(sx48(rand64()));
			end
		end
		if (style == 0 && n >= 2 && $urandom_range(3) == 0) begin
			times[0] = TIME_MIN;
			times[1] = TIME_MAX;
		end
		if (style != 2) times.sort();
		for (i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0) write_sample(i, times[i], $urandom_range(1) ? VAL_MAX : VAL_MIN);
			else write_sample(i, times[i], sx32(rand64()));
		end
	endtask

	// Picks a query time that lands in an interesting spot of the current table.
	function automatic longint pick_query();
		int     n, i;
		longint gap;
		n = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_count;
		if (n == 0) return sx48(rand64());
		i = $urandom_range(n - 1);
		case ($urandom_range(9))
			0, 1, 2: return shadow_time[i];
			3, 4, 5, 6: begin
				if (i + 1 < n) begin
					gap = shadow_time[i+1] - shadow_time[i];
					if (gap > 1) return shadow_time[i] + 1 + longint'(rand64() & 64'h7fff_ffff_ffff_ffff) % (gap - 1);
				end
				return shadow_time[i] + 1;
			end
			7: return $urandom_range(1) ? TIME_MIN : TIME_MAX;
			8: return (shadow_time[0] > TIME_MIN) ? shadow_time[0] - 1 : TIME_MIN;
			default: return sx48(rand64());
		endcase
	endfunction

	task automatic run_queries(input int count);
		int k;
		for (k = 0; k < count; k++) begin
			// A sprinkle of table writes mid-stream keeps the shadow honest.
			if (shadow_count > 0 && $urandom_range(19) == 0) begin
				write_sample($urandom_range(((shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_count) - 1),
					sx48(rand64()), sx32(rand64()));
			end else begin
				query_time(pick_query());
			end
		end
	endtask

	function automatic lookup_t mk(int f, bit e, longint v);
		lookup_t r;
		r.found = FOUND_W'(f);
		r.exact = e;
		r.value = VAL_W'(v);
		return r;
	endfunction

	function automatic void add_row(row_op_t op, int idx, longint t, longint v, bit typed, lookup_t ans);
		dir_row_t r;
		r.op = op;
		r.idx = idx;
		r.t = t;
		r.v = v;
		r.typed = typed;
		r.ans = ans;
		dir_rows.push_back(r);
	endfunction

	// Result checker and receiver side. The long hold-off is counted here so
	// that the sender keeps offering words while the block backs up.
	always @(posedge clk) begin : result_side
		lookup_t want;
		if (out_ch.valid && out_ch.ready) begin
			results_seen <= results_seen + 1;
			if (pending_lookups.size() == 0) begin
				errors++;
				$display("%0t: result word with nothing expected: found %0d exact %0d value %0d",
					$time, out_ch.found_index, out_ch.exact_hit, out_ch.result_value);
			end else begin
				want = pending_lookups.pop_front();
				if (out_ch.found_index !== want.found) begin
					errors++;
					$display("%0t: found_index expected %0d actual %0d",
						$time, want.found, out_ch.found_index);
				end
				if (out_ch.exact_hit !== want.exact) begin
					errors++;
					$display("%0t: exact_hit expected %0d actual %0d",
						$time, want.exact, out_ch.exact_hit);
				end
				if (out_ch.result_value !== want.value) begin
					errors++;
					$display("%0t: result_value expected %0d actual %0d",
						$time, want.value, out_ch.result_value);
				end
			end
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else if (!hold_done && results_seen >= 150) begin
			hold_done <= 1'b1;
			hold_left <= 600;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
		end
	end

	initial begin : stimulus
		int      n, style, phase;
		lookup_t none;
		// Every input starts at a known value.
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_WRITE;
		in_ch.entry_index = '0;
		in_ch.entry_time = '0;
		in_ch.entry_value = '0;
		in_ch.query_time = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		// Directed rows. With an empty table every query misses; then a
		// four-sample table checks miss below, exact hits at both ends, a
		// midpoint, past-the-end and the value extremes, then a rewrite with a
		// repeated time that only the predictor can answer, and a one-entry count.
		add_row(ROW_QUERY, 0, 0, 0, 1, mk(-1, 0, 0));
		add_row(ROW_QUERY, 0, TIME_MAX, 0, 1, mk(-1, 0, 0));
		add_row(ROW_WRITE, 0, -100, 32'h0001_0000, 0, none);
		add_row(ROW_WRITE, 1, 100, 32'h0003_0000, 0, none);
		add_row(ROW_WRITE, 2, 200, VAL_MIN, 0, none);
		add_row(ROW_WRITE, 3, 300, VAL_MAX, 0, none);
		add_row(ROW_WRITE, 1023, TIME_MAX, VAL_MAX, 0, none);
		add_row(ROW_WRITE, 1022, TIME_MIN, VAL_MIN, 0, none);
		add_row(ROW_COUNT, 0, 0, 4, 0, none);
		add_row(ROW_QUERY, 0, -200, 0, 1, mk(-1, 0, 0));
		add_row(ROW_QUERY, 0, TIME_MIN, 0, 1, mk(-1, 0, 0));
		add_row(ROW_QUERY, 0, -100, 0, 1, mk(0, 1, 32'h0001_0000));
		add_row(ROW_QUERY, 0, 0, 0, 1, mk(0, 0, 32'h0002_0000));
		add_row(ROW_QUERY, 0, 300, 0, 1, mk(3, 1, VAL_MAX));
		add_row(ROW_QUERY, 0, 400, 0, 1, mk(3, 0, 0));
		add_row(ROW_QUERY, 0, TIME_MAX, 0, 1, mk(3, 0, 0));
		add_row(ROW_QUERY, 0, 250, 0, 0, none);
		add_row(ROW_QUERY, 0, 150, 0, 0, none);
		add_row(ROW_WRITE, 1, 50, VAL_MAX, 0, none);
		add_row(ROW_WRITE, 2, 50, VAL_MIN, 0, none);
		add_row(ROW_QUERY, 0, 50, 0, 0, none);
		add_row(ROW_QUERY, 0, 20, 0, 0, none);
		add_row(ROW_QUERY, 0, 299, 0, 0, none);
		add_row(ROW_COUNT, 0, 0, 1, 0, none);
		add_row(ROW_QUERY, 0, -100, 0, 1, mk(0, 1, 32'h0001_0000));
		add_row(ROW_QUERY, 0, 0, 0, 1, mk(0, 0, 0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			case (dir_rows[i].op)
				ROW_COUNT: set_entry_count(int'(dir_rows[i].v));
				ROW_WRITE: write_sample(dir_rows[i].idx, dir_rows[i].t, dir_rows[i].v);
				default: send_word(KIND_QUERY, 0, dir_rows[i].t, rand64(), dir_rows[i].typed,
					dir_rows[i].ans);
			endcase
		end

		// Fill the whole table once, so that full and oversized counts never
		// touch an entry that was not written.
		set_entry_count(0);
		run_queries(10);
		load_table(TABLE_DEPTH, 0);
		set_entry_count(TABLE_DEPTH);
		run_queries(40);
		set_entry_count(2047);
		run_queries(30);
		set_entry_count(TABLE_DEPTH + 1);
		run_queries(10);

		// Small tables from here on: load, set the count, query. The idle pattern
		// swaps over a third of the way and drops to zero at two thirds.
		for (phase = 0; phase < 18; phase++) begin
			if (phase == 6) begin
				in_idle_pct = 68;
				out_idle_pct = 18;
			end else if (phase == 12) begin
				in_idle_pct = 0;
				out_idle_pct = 0;
			end
			n = ($urandom_range(7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
			style = ($urandom_range(7) == 0) ? 2 : $urandom_range(1);
			load_table(n, style);
			set_entry_count(($urandom_range(15) == 0) ? 0 : n);
			run_queries(10);
			// Halfway through the phase the sender waits for every result.
			in_ch.valid <= 1'b0;
			while (pending_lookups.size() != 0) @(posedge clk);
			run_queries(10);
		end

		in_ch.valid <= 1'b0;
		while (pending_lookups.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0) begin
			$display("tb_sorted_table_interpolation_top: clean");
		end else begin
			$display("tb_sorted_table_interpolation_top: errors");
		end
		$finish;
	end

endmodule
`default_nettype wire
